// ----- design/mfwp_pkg.sv -----
`default_nettype none

package mfwp_pkg;

   localparam int KIND_W   = 2;
   localparam int BUF_W    = 8;
   localparam int PC_W     = 16;
   localparam int STATUS_W = 2;
   localparam int FIRST_W  = 5;

   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_BUFFER  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_READ_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd3;

   // Result fields carried alongside the pending storage read.
   typedef struct packed {
      logic                pc_valid;
      logic [BUF_W-1:0]    buffer_out;
      logic [STATUS_W-1:0] status;
      logic                selected_empty;
      logic                all_empty;
      logic                any_ready;
      logic [FIRST_W-1:0]  first_ready;
   } rsp_info_type;

endpackage

`default_nettype wire

// ----- design/multi_fifo_window_picker.sv -----
// Bank of NUM_BUFFERS FIFOs of 16-bit program counters, FIFO_DEPTH entries each.
// Request channel (req_*): one operation per transaction: push, pop, peek or
// flush of all buffers, on req_buffer_id, with req_head marking the start of
// the scan window. Response channel (rsp_*): exactly one transaction per
// request, in order: the value read, a status code, emptiness flags and the
// first non-empty buffer of the window (head over NUM_BUFFERS-1 slots).
// A request passes the middle stage register, then the response register. One
// request is taken every cycle while req_ready is high; the limit is the single
// read port of the storage RAM, read at the request edge and sent on with the middle stage.
// Pointers and fill counts live in registers and are updated at the request
// edge, so a following request sees them at once.
// When rsp_ready is low the response register holds, the middle stage fills,
// and req_ready then drops until the response is taken.
// Reset empties every buffer; RAM contents are left as they are, and a read
// of an unwritten entry is discarded, as the response value is then zero.
`default_nettype none

module multi_fifo_window_picker
   import mfwp_pkg::*;
#(
   parameter int NUM_BUFFERS = 4,
   parameter int FIFO_DEPTH  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [BUF_W-1:0]    req_buffer_id,
   input  wire logic [PC_W-1:0]     req_pc_in,
   input  wire logic [BUF_W-1:0]    req_head,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [PC_W-1:0]     rsp_pc_out,
   output      logic [BUF_W-1:0]    rsp_buffer_out,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic                rsp_selected_empty,
   output      logic                rsp_all_empty,
   output      logic                rsp_any_ready,
   output      logic [FIRST_W-1:0]  rsp_first_ready
);

   localparam int ID_W      = $clog2(NUM_BUFFERS);
   localparam int PTR_W     = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W    = ID_W + PTR_W;
   localparam int MEM_DEPTH = NUM_BUFFERS << PTR_W;
   localparam int IDS       = 1 << BUF_W;

   // id modulo NUM_BUFFERS for every 8-bit value, built at elaboration
   function automatic logic [IDS*ID_W-1:0] build_mod_lut();
      logic [IDS*ID_W-1:0] lut;
      lut = '0;
      for (int v = 0; v < IDS; v++) begin
         lut[v*ID_W +: ID_W] = ID_W'(v % NUM_BUFFERS);
      end
      return lut;
   endfunction

   localparam logic [IDS*ID_W-1:0] MOD_LUT = build_mod_lut();

   logic [PC_W-1:0]    mem [MEM_DEPTH];
   logic [PC_W-1:0]    mem_rd_ff;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   logic               mem_we;

   logic [PTR_W-1:0]   rd_ptr_ff [NUM_BUFFERS];
   logic [PTR_W-1:0]   rd_ptr_in [NUM_BUFFERS];
   logic [PTR_W-1:0]   wr_ptr_ff [NUM_BUFFERS];
   logic [PTR_W-1:0]   wr_ptr_in [NUM_BUFFERS];
   logic [CNT_W-1:0]   fill_ff   [NUM_BUFFERS];
   logic [CNT_W-1:0]   fill_in   [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] nonempty;

   logic               op_pc_valid;
   logic [BUF_W-1:0]   op_buffer_out;
   logic [STATUS_W-1:0] op_status;

   logic               s1_valid_ff;
   rsp_info_type       s1_ff;
   rsp_info_type       s1_in;
   logic               s1_move;
   logic               accept;

   logic               rsp_valid_ff;
   logic [PC_W-1:0]    rsp_pc_ff;
   rsp_info_type       rsp_ff;

   logic [ID_W-1:0]    sel;
   logic [ID_W-1:0]    head_mod;
   logic [FIRST_W-1:0] first;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign sel      = MOD_LUT[ID_W*int'(req_buffer_id) +: ID_W];
   assign head_mod = MOD_LUT[ID_W*int'(req_head) +: ID_W];

   assign mem_waddr = {sel, wr_ptr_ff[sel]};
   assign mem_raddr = {sel, rd_ptr_ff[sel]};

   always_comb begin
      logic [PTR_W-1:0] rp;
      logic [PTR_W-1:0] wp;
      rp = rd_ptr_ff[sel];
      wp = wr_ptr_ff[sel];
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         rd_ptr_in[i] = rd_ptr_ff[i];
         wr_ptr_in[i] = wr_ptr_ff[i];
         fill_in[i]   = fill_ff[i];
      end
      mem_we        = 1'b0;
      op_pc_valid   = 1'b0;
      op_buffer_out = '0;
      op_status     = STATUS_OK;
      case (req_kind)
         KIND_PUSH: begin
            if (req_buffer_id >= BUF_W'(NUM_BUFFERS)) begin
               op_status = STATUS_NO_BUFFER;
            end else if (fill_ff[sel] == CNT_W'(FIFO_DEPTH)) begin
               op_status = STATUS_PUSH_FULL;
            end else begin
               mem_we         = accept;
               wr_ptr_in[sel] = (wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp + 1'b1;
               fill_in[sel]   = fill_ff[sel] + 1'b1;
            end
         end
         KIND_POP, KIND_PEEK: begin
            op_buffer_out = req_buffer_id;
            if (fill_ff[sel] == '0) begin
               op_status = STATUS_READ_EMPTY;
            end else begin
               op_pc_valid = 1'b1;
               if (req_kind == KIND_POP) begin
                  rd_ptr_in[sel] = (rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp + 1'b1;
                  fill_in[sel]   = fill_ff[sel] - 1'b1;
               end
            end
         end
         default: begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
               rd_ptr_in[i] = '0;
               wr_ptr_in[i] = '0;
               fill_in[i]   = '0;
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         nonempty[i] = (fill_in[i] != '0);
      end
   end

   // rotating priority pick over the window, last slot excluded
   always_comb begin
      logic [ID_W:0] slot;
      first = FIRST_W'(NUM_BUFFERS);
      slot  = '0;
      for (int i = NUM_BUFFERS - 2; i >= 0; i--) begin
         slot = {1'b0, head_mod} + (ID_W+1)'(i);
         if (slot >= (ID_W+1)'(NUM_BUFFERS)) begin
            slot = slot - (ID_W+1)'(NUM_BUFFERS);
         end
         if (nonempty[slot[ID_W-1:0]]) begin
            first = FIRST_W'(slot);
         end
      end
   end

   always_comb begin
      s1_in.pc_valid       = op_pc_valid;
      s1_in.buffer_out     = op_buffer_out;
      s1_in.status         = op_status;
      s1_in.selected_empty = !nonempty[sel];
      s1_in.all_empty      = ~|nonempty;
      s1_in.any_ready      = (first != FIRST_W'(NUM_BUFFERS));
      s1_in.first_ready    = first;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_pc_in;
      end
      if (accept) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else if (accept) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            rd_ptr_ff[i] <= rd_ptr_in[i];
            wr_ptr_ff[i] <= wr_ptr_in[i];
            fill_ff[i]   <= fill_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff    <= s1_ff;
         rsp_pc_ff <= s1_ff.pc_valid ? mem_rd_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pc_out         = rsp_pc_ff;
   assign rsp_buffer_out     = rsp_ff.buffer_out;
   assign rsp_status         = rsp_ff.status;
   assign rsp_selected_empty = rsp_ff.selected_empty;
   assign rsp_all_empty      = rsp_ff.all_empty;
   assign rsp_any_ready      = rsp_ff.any_ready;
   assign rsp_first_ready    = rsp_ff.first_ready;

   a_empty_read_stays_empty: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.status == STATUS_READ_EMPTY) |-> s1_ff.selected_empty)
      else $error("read of empty buffer left it non-empty");

   a_all_empty_no_pick: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.all_empty) |-> !s1_ff.any_ready)
      else $error("window pick while all buffers empty");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_FLUSH) |=> (s1_valid_ff && s1_ff.all_empty))
      else $error("flush did not empty all buffers");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.any_ready) |-> (s1_ff.first_ready < FIRST_W'(NUM_BUFFERS)))
      else $error("window pick out of range");

endmodule

`default_nettype wire

// ----- bench/tb_multi_fifo_window_picker.sv -----
`timescale 1ns / 100ps

module tb_multi_fifo_window_picker;
   import mfwp_pkg::*;

   localparam int NUM_BUFS   = 4;
   localparam int FIFO_DEPTH = 16;
   localparam int NUM_RANDOM = 1000;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [PC_W-1:0]     pc_out;
      logic [BUF_W-1:0]    buffer_out;
      logic [STATUS_W-1:0] status;
      logic                selected_empty;
      logic                all_empty;
      logic                any_ready;
      logic [FIRST_W-1:0]  first_ready;
   } pc_result_type;

   // Mirror of the buffer bank plus the queue of responses still owed.
   class pc_bank_scoreboard;
      logic [PC_W-1:0] slots [NUM_BUFS][FIFO_DEPTH];
      int              rd_ptr [NUM_BUFS];
      int              wr_ptr [NUM_BUFS];
      int              fill [NUM_BUFS];
      pc_result_type   pending_results [$];
      int              errors;

      function new();
         for (int b = 0; b < NUM_BUFS; b++) begin
            rd_ptr[b] = 0;
            wr_ptr[b] = 0;
            fill[b]   = 0;
         end
         errors = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [BUF_W-1:0] id,
                                 logic [PC_W-1:0] pc, logic [BUF_W-1:0] head);
         pc_result_type r;
         int sel;
         int b;
         r = '0;
         sel = int'(id) % NUM_BUFS;
         r.first_ready = FIRST_W'(NUM_BUFS);
         r.all_empty = 1'b1;
         case (kind)
            KIND_PUSH: begin
               if (int'(id) >= NUM_BUFS) begin
                  r.status = STATUS_NO_BUFFER;
               end else if (fill[id] >= FIFO_DEPTH) begin
                  r.status = STATUS_PUSH_FULL;
               end else begin
                  slots[id][wr_ptr[id]] = pc;
                  wr_ptr[id] = (wr_ptr[id] + 1) % FIFO_DEPTH;
                  fill[id]++;
               end
            end
            KIND_POP, KIND_PEEK: begin
               r.buffer_out = id;
               if (fill[sel] == 0) begin
                  r.status = STATUS_READ_EMPTY;
               end else begin
                  r.pc_out = slots[sel][rd_ptr[sel]];
                  if (kind == KIND_POP) begin
                     rd_ptr[sel] = (rd_ptr[sel] + 1) % FIFO_DEPTH;
                     fill[sel]--;
                  end
               end
            end
            default: begin
               for (int i = 0; i < NUM_BUFS; i++) begin
                  rd_ptr[i] = 0;
                  wr_ptr[i] = 0;
                  fill[i]   = 0;
               end
            end
         endcase
         for (int i = 0; i < NUM_BUFS; i++)
            if (fill[i] != 0) r.all_empty = 1'b0;
         // window skips its last slot
         for (int i = 0; i < NUM_BUFS - 1; i++) begin
            b = (int'(head) + i) % NUM_BUFS;
            if (fill[b] != 0) begin
               r.first_ready = FIRST_W'(b);
               r.any_ready = 1'b1;
               break;
            end
         end
         r.selected_empty = (fill[sel] == 0);
         pending_results = {pending_results, r};
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(pc_result_type got);
         pc_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response transaction: actual 0x%0h", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("pc_out", want.pc_out, got.pc_out);
         compare_field("buffer_out", want.buffer_out, got.buffer_out);
         compare_field("status", want.status, got.status);
         compare_field("selected_empty", want.selected_empty, got.selected_empty);
         compare_field("all_empty", want.all_empty, got.all_empty);
         compare_field("any_ready", want.any_ready, got.any_ready);
         compare_field("first_ready", want.first_ready, got.first_ready);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = KIND_PUSH;
   logic [BUF_W-1:0]    req_buffer_id = '0;
   logic [PC_W-1:0]     req_pc_in = '0;
   logic [BUF_W-1:0]    req_head = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [PC_W-1:0]     rsp_pc_out;
   logic [BUF_W-1:0]    rsp_buffer_out;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_selected_empty;
   logic                rsp_all_empty;
   logic                rsp_any_ready;
   logic [FIRST_W-1:0]  rsp_first_ready;

   pc_bank_scoreboard sb = new();
   bit req_no_idle = 1'b0;
   bit rsp_no_idle = 1'b0;
   int rsp_stall_left = 0;
   int cycles = 0;

   multi_fifo_window_picker #(
      .NUM_BUFFERS(NUM_BUFS),
      .FIFO_DEPTH(FIFO_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_buffer_id(req_buffer_id),
      .req_pc_in(req_pc_in),
      .req_head(req_head),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pc_out(rsp_pc_out),
      .rsp_buffer_out(rsp_buffer_out),
      .rsp_status(rsp_status),
      .rsp_selected_empty(rsp_selected_empty),
      .rsp_all_empty(rsp_all_empty),
      .rsp_any_ready(rsp_any_ready),
      .rsp_first_ready(rsp_first_ready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** multi_fifo_window_picker: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function int idle_gap(bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // response side: sample at the edge, then choose ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_pc_out, rsp_buffer_out, rsp_status,
                               rsp_selected_empty, rsp_all_empty,
                               rsp_any_ready, rsp_first_ready});
         if ($urandom_range(0, 199) == 0) rsp_no_idle = ~rsp_no_idle;
         if (rsp_stall_left > 0) begin
            rsp_stall_left = rsp_stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_stall_left = idle_gap(rsp_no_idle);
            rsp_ready <= (rsp_stall_left == 0);
         end
      end
   end

   // valid stays high across back-to-back transactions
   task automatic send_request(logic [KIND_W-1:0] kind, logic [BUF_W-1:0] id,
                               logic [PC_W-1:0] pc, logic [BUF_W-1:0] head);
      int gap;
      gap = idle_gap(req_no_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_buffer_id <= id;
      req_pc_in     <= pc;
      req_head      <= head;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, id, pc, head);
   endtask

   initial begin
      int push_bias;
      int focus_id;
      int r;
      logic [KIND_W-1:0] kind;
      logic [BUF_W-1:0]  id;
      logic [BUF_W-1:0]  head;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, bad ids, window edges, full buffer, flush
      send_request(KIND_POP, 8'd0, 16'h0000, 8'd0);
      send_request(KIND_PEEK, 8'hFF, 16'hFFFF, 8'hFF);
      send_request(KIND_PUSH, 8'(NUM_BUFS), 16'h5A5A, 8'd0);
      send_request(KIND_PUSH, 8'hFF, 16'hFFFF, 8'd0);
      send_request(KIND_PUSH, 8'(NUM_BUFS - 1), 16'hFFFF, 8'hFF);
      // buffer 0 lands in the excluded last slot of a window starting at 1
      send_request(KIND_PUSH, 8'd0, 16'h0000, 8'd1);
      send_request(KIND_PEEK, 8'd7, 16'h0000, 8'd0);
      send_request(KIND_POP, 8'(NUM_BUFS - 1), 16'h0000, 8'd2);
      send_request(KIND_POP, 8'd0, 16'h0000, 8'd0);
      for (int i = 0; i < FIFO_DEPTH; i++)
         send_request(KIND_PUSH, 8'd2, 16'(i * 16'h1111 + 16'h0F0F), 8'(i * 17));
      send_request(KIND_PUSH, 8'd2, 16'hDEAD, 8'd3);
      send_request(KIND_PEEK, 8'd2, 16'h0000, 8'd2);
      send_request(KIND_FLUSH, 8'hFF, 16'hFFFF, 8'hFF);

      push_bias = 50;
      focus_id = 0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 60 == 0) begin
            r = $urandom_range(0, 2);
            push_bias = (r == 0) ? 25 : (r == 1) ? 55 : 85;
            focus_id = $urandom_range(0, NUM_BUFS - 1);
         end
         if ($urandom_range(0, 59) == 0) req_no_idle = ~req_no_idle;

         r = $urandom_range(0, 99);
         if (r < 2) kind = KIND_FLUSH;
         else if ($urandom_range(0, 99) < push_bias) kind = KIND_PUSH;
         else if ($urandom_range(0, 99) < 70) kind = KIND_POP;
         else kind = KIND_PEEK;

         r = $urandom_range(0, 99);
         if (r < 50) id = 8'(focus_id);
         else if (r < 85) id = 8'($urandom_range(0, NUM_BUFS - 1));
         else id = 8'($urandom_range(0, 255));

         if ($urandom_range(0, 1) == 0) head = 8'($urandom_range(0, NUM_BUFS - 1));
         else head = 8'($urandom_range(0, 255));

         send_request(kind, id, 16'($urandom_range(0, 65535)), head);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("** multi_fifo_window_picker: PASSED **");
      else
         $display("** multi_fifo_window_picker: FAILED **");
      $finish;
   end

endmodule
